@@ rtl/ftrl_proximal_weight_update_unit_macros.svh @@
// Assertion macros for the FTRL-Proximal weight update unit.
// Used by the checker; no other dependencies.
`ifndef FTRL_PROXIMAL_WEIGHT_UPDATE_UNIT_MACROS_SVH
`define FTRL_PROXIMAL_WEIGHT_UPDATE_UNIT_MACROS_SVH

// Property checked outside reset.
`define FTRL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define FTRL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/ftrl_pkg.sv @@
// Shared types and constants of the FTRL-Proximal weight update unit.
// No dependencies.
package ftrl_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = 16;
    localparam int DATA_W     = 32;
    localparam int REG_W      = 31;
    localparam int ADDR_W     = 4;
    localparam int S_TDATA_W  = 112;
    localparam int M_TDATA_W  = 48;
    localparam int ROOT_W     = 24;
    localparam int RAD_W      = 48;
    localparam int SREM_W     = 28;
    localparam int DIV_W      = 48;
    localparam int DVS_W      = 49;
    localparam int STEP_W     = 6;
    localparam int SQRT_STEPS = 24;
    localparam int DIV_STEPS  = 48;

    localparam logic [REG_W-1:0] ALPHA_RST = 31'd6554;
    localparam logic [REG_W-1:0] BETA_RST  = 31'd65536;
    localparam logic [REG_W-1:0] L1_RST    = 31'd65536;
    localparam logic [REG_W-1:0] L2_RST    = 31'd65536;

    typedef enum logic [1:0] {
        REG_ALPHA = 2'd0,
        REG_BETA  = 2'd1,
        REG_L1    = 2'd2,
        REG_L2    = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_GRAD,
        ST_GSAT,
        ST_GSQ,
        ST_NNEW,
        ST_SQRT,
        ST_DIV_SIG,
        ST_DIV_DEN,
        ST_TERM,
        ST_ZUPD,
        ST_ZCHK,
        ST_DIV_Q,
        ST_SIGN,
        ST_WRITE
    } state_t;

endpackage

@@ rtl/ftrl_proximal_weight_update_unit.sv @@
// One item at a time: the next item is accepted only once the result of the last one is
// registered, the time per item being set by the shared divider (up to three 48-step
// divisions, the last skipped when the denominator is zero or |z| stays within l1) and
// the two-lane square root unit (24 steps); a stalled result holds the next accept.
// Reset (aresetn low, synchronous) restores the registers, then a clearing pass over
// all 65536 entries zeroes the z, n and weight store; no item is accepted meanwhile.
module ftrl_proximal_weight_update_unit
    import ftrl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // feature_index[15:0], feature_value[47:16], prediction[79:48], label[111:80]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // weight_index[15:0], new_weight[47:16]
    output logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    localparam int DEPTH = 1 << IDX_W;

    // Configuration registers
    logic [REG_W-1:0] alpha_reg, beta_reg, l1_reg, l2_reg;
    logic [DVS_W-1:0] alpha_eff;
    reg_idx_t         cfg_sel;

    assign pready  = 1'b1;
    assign cfg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= ALPHA_RST;
            beta_reg  <= BETA_RST;
            l1_reg    <= L1_RST;
            l2_reg    <= L2_RST;
        end else if (psel && penable && pwrite) begin
            unique case (cfg_sel)
                REG_ALPHA: alpha_reg <= pwdata[REG_W-1:0];
                REG_BETA:  beta_reg  <= pwdata[REG_W-1:0];
                REG_L1:    l1_reg    <= pwdata[REG_W-1:0];
                REG_L2:    l2_reg    <= pwdata[REG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_ALPHA: prdata = {1'b0, alpha_reg};
            REG_BETA:  prdata = {1'b0, beta_reg};
            REG_L1:    prdata = {1'b0, l1_reg};
            REG_L2:    prdata = {1'b0, l2_reg};
            default:   prdata = '0;
        endcase
    end

    // Zero alpha acts as the smallest step
    assign alpha_eff = (alpha_reg == '0) ? DVS_W'(1) : {{(DVS_W-REG_W){1'b0}}, alpha_reg};

    // Control and datapath registers
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_cnt_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [IDX_W-1:0]     idx_reg;
    logic [DATA_W-1:0]    value_reg, pred_reg, label_reg;
    logic [DATA_W-1:0]    z_rd_reg, n_rd_reg, w_rd_reg;
    logic [63:0]          prod_reg;
    logic [DATA_W-1:0]    g_reg;
    logic [63:0]          sq_reg;
    logic [DATA_W-1:0]    n_new_reg;
    logic [RAD_W-1:0]     rad_reg   [2];
    logic [SREM_W-1:0]    srem_reg  [2];
    logic [ROOT_W-1:0]    root_reg  [2];
    logic [DVS_W-1:0]     rem_reg, dvs_reg, den_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [REG_W-1:0]     sigma_reg;
    logic [47:0]          term_reg;
    logic [DATA_W-1:0]    z_new_reg, qmag_reg, w_new_reg;

    logic out_free, accept, mem_we, last_sqrt, last_div;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign last_sqrt = (step_reg == STEP_W'(SQRT_STEPS - 1));
    assign last_div  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Arithmetic of the individual steps
    logic signed [32:0]      diff;
    logic signed [64:0]      prod_full;
    logic signed [63:0]      gshift;
    logic [DATA_W-1:0]       g_sat, gmag, zmag;
    logic [48:0]             nsum;
    logic signed [63:0]      term_full;
    logic signed [49:0]      zsum;
    logic [DATA_W-1:0]       z_sat;
    logic [49:0]             div_sh, dvs_ext;
    logic                    div_ge;
    logic [DVS_W-1:0]        rem_step;
    logic [DIV_W-1:0]        quo_step;
    logic [DATA_W-1:0]       beta_sum;
    logic [SREM_W-1:0]       srem_sh   [2];
    logic [SREM_W-1:0]       strial    [2];
    logic [SREM_W-1:0]       srem_step [2];
    logic [ROOT_W-1:0]       root_step [2];

    always_comb begin
        diff      = $signed({pred_reg[31], pred_reg}) - $signed({label_reg[31], label_reg});
        prod_full = diff * $signed(value_reg);
        gshift    = $signed(prod_reg) >>> FRAC_BITS;
        if (gshift[63:31] != {33{gshift[63]}}) begin
            g_sat = gshift[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            g_sat = gshift[31:0];
        end
        gmag      = g_reg[31] ? (~g_reg + 32'd1) : g_reg;
        nsum      = {17'd0, n_rd_reg} + {1'b0, sq_reg[63:16]};
        term_full = $signed({1'b0, sigma_reg}) * $signed(w_rd_reg);
        zsum      = $signed({{18{z_rd_reg[31]}}, z_rd_reg}) + $signed({{18{g_reg[31]}}, g_reg})
                    - $signed({{2{term_reg[47]}}, term_reg});
        if (zsum[49:31] != {19{zsum[49]}}) begin
            z_sat = zsum[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            z_sat = zsum[31:0];
        end
        zmag      = z_new_reg[31] ? (~z_new_reg + 32'd1) : z_new_reg;
        // Restoring division, one quotient bit per cycle
        div_sh    = {rem_reg, quo_reg[DIV_W-1]};
        dvs_ext   = {1'b0, dvs_reg};
        div_ge    = (div_sh >= dvs_ext);
        rem_step  = div_ge ? DVS_W'(div_sh - dvs_ext) : div_sh[DVS_W-1:0];
        quo_step  = {quo_reg[DIV_W-2:0], div_ge};
        beta_sum  = {1'b0, beta_reg} + {8'd0, root_reg[1]};
        // Two square root lanes, one root bit per cycle
        for (int i = 0; i < 2; i++) begin
            srem_sh[i] = {srem_reg[i][SREM_W-3:0], rad_reg[i][RAD_W-1:RAD_W-2]};
            strial[i]  = {2'b00, root_reg[i], 2'b01};
            if (srem_sh[i] >= strial[i]) begin
                srem_step[i] = srem_sh[i] - strial[i];
                root_step[i] = {root_reg[i][ROOT_W-2:0], 1'b1};
            end else begin
                srem_step[i] = srem_sh[i];
                root_step[i] = {root_reg[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mem_we     = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (clr_cnt_reg == IDX_W'(DEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) state_next = ST_READ;
            end
            ST_READ:    state_next = ST_GRAD;
            ST_GRAD:    state_next = ST_GSAT;
            ST_GSAT:    state_next = ST_GSQ;
            ST_GSQ:     state_next = ST_NNEW;
            ST_NNEW:    state_next = ST_SQRT;
            ST_SQRT:    if (last_sqrt) state_next = ST_DIV_SIG;
            ST_DIV_SIG: if (last_div) state_next = ST_DIV_DEN;
            ST_DIV_DEN: if (last_div) state_next = ST_TERM;
            ST_TERM:    state_next = ST_ZUPD;
            ST_ZUPD:    state_next = ST_ZCHK;
            ST_ZCHK: begin
                if (zmag <= {1'b0, l1_reg}) state_next = ST_WRITE;
                else if (den_reg == '0)     state_next = ST_SIGN;
                else                        state_next = ST_DIV_Q;
            end
            ST_DIV_Q:   if (last_div) state_next = ST_SIGN;
            ST_SIGN:    state_next = ST_WRITE;
            ST_WRITE: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Clear counter, step counter and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            if ((state_reg == ST_SQRT && last_sqrt) ||
                ((state_reg == ST_DIV_SIG || state_reg == ST_DIV_DEN ||
                  state_reg == ST_DIV_Q) && last_div) ||
                state_reg == ST_NNEW || state_reg == ST_ZCHK) begin
                step_reg <= '0;
            end else begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (state_reg == ST_WRITE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath sequencing
    always_ff @(posedge aclk) begin
        if (accept) begin
            idx_reg   <= s_tdata[15:0];
            value_reg <= s_tdata[47:16];
            pred_reg  <= s_tdata[79:48];
            label_reg <= s_tdata[111:80];
        end
        if (state_reg == ST_WRITE && out_free) m_tdata_reg <= {w_new_reg, idx_reg};
        case (state_reg)
            ST_GRAD: prod_reg <= prod_full[63:0];
            ST_GSAT: g_reg    <= g_sat;
            ST_GSQ:  sq_reg   <= gmag * gmag;
            ST_NNEW: begin
                n_new_reg   <= (nsum[48:32] != '0) ? 32'hFFFF_FFFF : nsum[31:0];
                rad_reg[0]  <= {n_rd_reg, 16'd0};
                rad_reg[1]  <= (nsum[48:32] != '0) ? {32'hFFFF_FFFF, 16'd0}
                                                   : {nsum[31:0], 16'd0};
                srem_reg[0] <= '0;
                srem_reg[1] <= '0;
                root_reg[0] <= '0;
                root_reg[1] <= '0;
            end
            ST_SQRT: begin
                for (int i = 0; i < 2; i++) begin
                    rad_reg[i]  <= {rad_reg[i][RAD_W-3:0], 2'b00};
                    srem_reg[i] <= srem_step[i];
                    root_reg[i] <= root_step[i];
                end
                // Load the sigma division once both roots are final
                if (last_sqrt) begin
                    rem_reg <= '0;
                    dvs_reg <= alpha_eff;
                    quo_reg <= {8'd0, root_step[1] - root_step[0], 16'd0};
                end
            end
            ST_DIV_SIG: begin
                // Saturate sigma, then load the denominator division
                if (last_div) begin
                    sigma_reg <= (quo_step[47:31] != '0) ? 31'h7FFF_FFFF : quo_step[30:0];
                    rem_reg   <= '0;
                    quo_reg   <= {beta_sum, 16'd0};
                end else begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                end
            end
            ST_DIV_DEN: begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                if (last_div) den_reg <= {1'b0, quo_step} + {18'd0, l2_reg};
            end
            ST_TERM: term_reg  <= term_full[63:16];
            ST_ZUPD: z_new_reg <= z_sat;
            ST_ZCHK: begin
                w_new_reg <= '0;
                qmag_reg  <= 32'h8000_0000;
                rem_reg   <= '0;
                dvs_reg   <= den_reg;
                quo_reg   <= {zmag - {1'b0, l1_reg}, 16'd0};
            end
            ST_DIV_Q: begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                if (last_div) begin
                    if (quo_step[47:32] != '0 || (quo_step[31] && quo_step[30:0] != '0)) begin
                        qmag_reg <= 32'h8000_0000;
                    end else begin
                        qmag_reg <= quo_step[31:0];
                    end
                end
            end
            ST_SIGN: begin
                if (z_new_reg[31]) begin
                    w_new_reg <= qmag_reg[31] ? 32'h7FFF_FFFF : qmag_reg;
                end else begin
                    w_new_reg <= 32'd0 - qmag_reg;
                end
            end
            default: ;
        endcase
    end

    // State store: z, n and weight side by side, one write and one read port
    logic [3*DATA_W-1:0] st_mem [DEPTH];
    logic [IDX_W-1:0]    wr_addr;
    logic                clearing;

    assign clearing = (state_reg == ST_CLEAR);
    assign wr_addr  = clearing ? clr_cnt_reg : idx_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            st_mem[wr_addr] <= clearing ? '0 : {z_new_reg, n_new_reg, w_new_reg};
        end
        {z_rd_reg, n_rd_reg, w_rd_reg} <= st_mem[idx_reg];
    end

endmodule

@@ rtl/ftrl_checker.sv @@
// Port-level checks of the FTRL-Proximal weight update unit, bound to the top.
// Depends on ftrl_pkg and ftrl_proximal_weight_update_unit_macros.svh.
`include "ftrl_proximal_weight_update_unit_macros.svh"
module ftrl_checker
    import ftrl_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A stalled result item stays valid and unchanged
    `FTRL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `FTRL_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")
    // One item in flight: no accept right after an accept
    `FTRL_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "second item taken while busy")
    // Store clearing blocks input right after reset
    `FTRL_ASSERT_ALWAYS(a_clear_block, !aresetn |=> !s_tready, "item taken during store clearing")

endmodule

bind ftrl_proximal_weight_update_unit ftrl_checker u_ftrl_checker (.*);
